// ----- src/fpa_pkg.sv -----
// Package for the 17.14 fixed-point ALU: action codes, item types and the divider cell record.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int WORD_WIDTH_DEF    = 32;

    // Fixed storage widths; the word width parameter selects how much of them is used.
    localparam int OPD_W = 32;
    localparam int PRD_W = 64;
    localparam int DVD_W = 64;
    localparam int REM_W = 33;

    typedef enum logic [3:0] {
        ACT_INT_TO_FIX = 4'd0,
        ACT_FIX_TO_INT = 4'd1,
        ACT_ROUND      = 4'd2,
        ACT_ADD_INT    = 4'd3,
        ACT_ADD_FIX    = 4'd4,
        ACT_SUB_INT    = 4'd5,
        ACT_SUB_FIX    = 4'd6,
        ACT_MUL_INT    = 4'd7,
        ACT_MUL_FIX    = 4'd8,
        ACT_DIV_INT    = 4'd9,
        ACT_DIV_FIX    = 4'd10
    } fpa_action_t;

    typedef struct packed {
        logic [3:0]        action;
        logic [OPD_W-1:0]  operand_a;
        logic [OPD_W-1:0]  operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic [OPD_W-1:0]  result;
        logic              divide_by_zero;
    } fpa_out_t;

    // Everything one item carries down the divider row.
    typedef struct packed {
        logic [3:0]        action;
        logic [OPD_W-1:0]  a;
        logic [OPD_W-1:0]  b;
        logic [PRD_W-1:0]  prod;
        logic [DVD_W-1:0]  dvd;
        logic [OPD_W-1:0]  dvs;
        logic [REM_W-1:0]  rem;
        logic [OPD_W-1:0]  quo;
        logic              qneg;
    } fpa_cell_t;

endpackage

// ----- src/fixed_point_17_14_alu.sv -----
// Top level of the 17.14 fixed-point ALU: entry stage, divider row and result stage.
`timescale 1ns / 1ps
//
//  Channel   Signals                        Direction  Carries
//  in        in_valid, in_ready, in_data     input      action, operand_a, operand_b
//  out       out_valid, out_ready, out_data  output     result, divide_by_zero
//
// Every item passes from the entry register through the row of one-bit
// division cells to the result register.
// Unless the output stalls, a new item is accepted and taken in every cycle.
// Each stage moves whenever the stage after it is empty or moving, so bubbles
// close up and items keep entering while a finished result waits at the output.
// Reset clears only the valid bits of the stages.
module fixed_point_17_14_alu
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int WORD_WIDTH    = WORD_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fpa_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output fpa_out_t out_data
);

    // Number of dividend bits: a fixed-point dividend is the operand scaled up.
    localparam int DEPTH     = WORD_WIDTH + FRACTION_BITS;
    localparam int DVD_SHIFT = DVD_W - DEPTH;

    // Stage 0 is the entry register; stages 1..DEPTH are the division cells.
    fpa_cell_t stg   [0:DEPTH];
    logic      vld   [0:DEPTH];
    logic      move  [0:DEPTH];

    // Entry stage: operands are sign-extended from the word width, the
    // product is formed and the divider operands are prepared.
    logic              entry_valid_reg;
    logic              entry_valid_next;
    fpa_cell_t         entry_reg;
    fpa_cell_t         entry_next;
    logic signed [PRD_W-1:0] a_wide;
    logic signed [PRD_W-1:0] b_wide;
    logic [OPD_W-1:0]  a_ext;
    logic [OPD_W-1:0]  b_ext;
    logic [DVD_W-1:0]  mag_a;
    logic [DVD_W-1:0]  mag_b;
    logic [DVD_W-1:0]  dividend;

    always_comb
    begin
        for (int i = 0; i < OPD_W; i++)
        begin
            a_ext[i] = (i < WORD_WIDTH) ? in_data.operand_a[i] : in_data.operand_a[WORD_WIDTH-1];
            b_ext[i] = (i < WORD_WIDTH) ? in_data.operand_b[i] : in_data.operand_b[WORD_WIDTH-1];
        end
        a_wide   = PRD_W'($signed(a_ext));
        b_wide   = PRD_W'($signed(b_ext));
        mag_a    = a_ext[OPD_W-1] ? DVD_W'(-a_wide) : DVD_W'(a_wide);
        mag_b    = b_ext[OPD_W-1] ? DVD_W'(-b_wide) : DVD_W'(b_wide);
        dividend = (in_data.action == ACT_DIV_FIX) ? (mag_a << FRACTION_BITS) : mag_a;

        entry_next.action = in_data.action;
        entry_next.a      = a_ext;
        entry_next.b      = b_ext;
        entry_next.prod   = PRD_W'($signed(a_ext) * $signed(b_ext));
        entry_next.dvd    = dividend << DVD_SHIFT;
        entry_next.dvs    = mag_b[OPD_W-1:0];
        entry_next.rem    = '0;
        entry_next.quo    = '0;
        entry_next.qneg   = a_ext[OPD_W-1] ^ b_ext[OPD_W-1];

        entry_valid_next  = in_ready ? in_valid : entry_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            entry_reg <= entry_next;
        end
    end

    assign stg[0]   = entry_reg;
    assign vld[0]   = entry_valid_reg;
    assign in_ready = !vld[0] || move[0];

    // Stage k may hand its item on when stage k+1 is empty or moving itself.
    generate
        for (genvar k = 0; k < DEPTH; k++)
        begin : g_row
            assign move[k] = !vld[k+1] || move[k+1];

            fpa_div_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (move[k]),
                .prev_valid (vld[k]),
                .prev       (stg[k]),
                .valid      (vld[k+1]),
                .data       (stg[k+1])
            );
        end
    endgenerate

    // Result stage: the operation is selected and wrapped to the word width.
    logic              out_valid_reg;
    logic              out_valid_next;
    fpa_out_t          out_reg;
    fpa_out_t          out_next;
    fpa_cell_t         last;
    logic signed [PRD_W-1:0] la;
    logic signed [PRD_W-1:0] lb;
    logic [PRD_W-1:0]  rnd_mag;
    logic [PRD_W-1:0]  rnd_q;
    logic [PRD_W-1:0]  quo_wide;
    logic [PRD_W-1:0]  raw;
    logic              dz;

    assign move[DEPTH] = !out_valid_reg || out_ready;

    always_comb
    begin
        last     = stg[DEPTH];
        la       = PRD_W'($signed(last.a));
        lb       = PRD_W'($signed(last.b));
        rnd_mag  = last.a[OPD_W-1] ? PRD_W'(-la) : PRD_W'(la);
        rnd_q    = (rnd_mag + (PRD_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        quo_wide = {{(PRD_W-OPD_W){1'b0}}, last.quo};
        dz       = 1'b0;
        raw      = '0;
        unique case (last.action)
            ACT_INT_TO_FIX: raw = PRD_W'(lb <<< FRACTION_BITS);
            ACT_FIX_TO_INT: raw = PRD_W'(la >>> FRACTION_BITS);
            ACT_ROUND:      raw = last.a[OPD_W-1] ? (PRD_W'(0) - rnd_q) : rnd_q;
            ACT_ADD_INT:    raw = PRD_W'(la + (lb <<< FRACTION_BITS));
            ACT_ADD_FIX:    raw = PRD_W'(la + lb);
            ACT_SUB_INT:    raw = PRD_W'(la - (lb <<< FRACTION_BITS));
            ACT_SUB_FIX:    raw = PRD_W'(la - lb);
            ACT_MUL_INT:    raw = last.prod;
            ACT_MUL_FIX:    raw = PRD_W'($signed(last.prod) >>> FRACTION_BITS);
            ACT_DIV_INT, ACT_DIV_FIX:
            begin
                if (last.b == '0)
                begin
                    dz  = 1'b1;
                    raw = '0;
                end
                else
                begin
                    raw = last.qneg ? (PRD_W'(0) - quo_wide) : quo_wide;
                end
            end
            default:        raw = '0;
        endcase

        // Wrap modulo 2^WORD_WIDTH and sign-extend into the result field.
        for (int i = 0; i < OPD_W; i++)
        begin
            out_next.result[i] = (i < WORD_WIDTH) ? raw[i] : raw[WORD_WIDTH-1];
        end
        out_next.divide_by_zero = dz;

        out_valid_next = move[DEPTH] ? vld[DEPTH] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[DEPTH])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // A flagged division always returns zero.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.divide_by_zero) |-> (out_data.result == '0))
        else $error("divide_by_zero set with a nonzero result");

    // The input side only stalls while the entry stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> vld[0])
        else $error("input stalled with an empty entry stage");

    // An item leaving the last cell shows up at the output next cycle.
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld[DEPTH] && move[DEPTH]) |=> out_valid)
        else $error("item lost between the divider row and the output");
`endif

endmodule

// ----- src/fpa_div_cell.sv -----
// One restoring-division step of the divider row, with its pipeline register.
`timescale 1ns / 1ps
module fpa_div_cell
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      prev_valid,
    input  fpa_cell_t prev,
    output logic      valid,
    output fpa_cell_t data
);

    logic      valid_reg;
    logic      valid_next;
    fpa_cell_t data_reg;
    fpa_cell_t data_next;
    logic [REM_W-1:0] shifted;
    logic             fits;

    always_comb
    begin
        shifted   = {prev.rem[REM_W-2:0], prev.dvd[DVD_W-1]};
        fits      = shifted >= {1'b0, prev.dvs};
        data_next = prev;
        data_next.rem = fits ? (shifted - {1'b0, prev.dvs}) : shifted;
        data_next.quo = {prev.quo[OPD_W-2:0], fits};
        data_next.dvd = {prev.dvd[DVD_W-2:0], 1'b0};
        valid_next    = load ? prev_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- dv/fixed_point_17_14_alu_tb.sv -----
// Self-checking testbench for the 17.14 fixed-point ALU with random and directed items.
`timescale 1ns / 1ps

// Holds the results the ALU owes and checks each one it delivers, in order.
class fpa_result_book;
    fpa_pkg::fpa_out_t owed[$];
    int mismatches;

    // Computes what the ALU returns for one item and queues it.
    function void note_item(fpa_pkg::fpa_in_t it);
        fpa_pkg::fpa_out_t r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        logic [31:0] mag;
        logic [32:0] q;
        a = it.operand_a;
        b = it.operand_b;
        r.result = '0;
        r.divide_by_zero = 1'b0;
        case (it.action)
            fpa_pkg::ACT_INT_TO_FIX: r.result = b <<< 14;
            fpa_pkg::ACT_FIX_TO_INT: r.result = a >>> 14;
            fpa_pkg::ACT_ROUND:
            begin
                // Halves go away from zero, so round the magnitude.
                mag = (a < 0) ? -a : a;
                q = ({1'b0, mag} + 33'd8192) >> 14;
                r.result = (a < 0) ? -q[31:0] : q[31:0];
            end
            fpa_pkg::ACT_ADD_INT: r.result = a + (b <<< 14);
            fpa_pkg::ACT_ADD_FIX: r.result = a + b;
            fpa_pkg::ACT_SUB_INT: r.result = a - (b <<< 14);
            fpa_pkg::ACT_SUB_FIX: r.result = a - b;
            fpa_pkg::ACT_MUL_INT: r.result = a * b;
            fpa_pkg::ACT_MUL_FIX:
            begin
                wide = 64'(a) * 64'(b);
                wide = wide >>> 14;
                r.result = wide[31:0];
            end
            fpa_pkg::ACT_DIV_INT, fpa_pkg::ACT_DIV_FIX:
            begin
                if (b == 0)
                begin
                    r.divide_by_zero = 1'b1;
                end
                else
                begin
                    num = 64'(a);
                    if (it.action == fpa_pkg::ACT_DIV_FIX)
                        num = num <<< 14;
                    wide = num / 64'(b);
                    r.result = wide[31:0];
                end
            end
            default: r.result = '0;
        endcase
        owed.push_back(r);
    endfunction

    function void check_result(fpa_pkg::fpa_out_t got);
        fpa_pkg::fpa_out_t exp_r;
        if (owed.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h/%b", got.result, got.divide_by_zero);
            return;
        end
        exp_r = owed.pop_front();
        if (got !== exp_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h/%b, got %h/%b",
                         exp_r.result, exp_r.divide_by_zero,
                         got.result, got.divide_by_zero);
        end
    endfunction
endclass

module fixed_point_17_14_alu_tb;
    import fpa_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    fpa_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    fpa_out_t out_data;

    fpa_result_book book;
    // Percentages of cycles in which each side holds back.
    int send_idle;
    int recv_idle;
    int cycles;

    fixed_point_17_14_alu dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // The receiver stalls at random; every result taken is checked at once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                book.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // The run is cut off if the ALU stops delivering.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("fixed_point_17_14_alu_tb NOT OK");
            $finish;
        end
    end

    // Offers one item after a random gap and holds it until it is taken.
    // Valid stays high after acceptance until the next gap or drain lowers it.
    task automatic send_item(input logic [3:0] act, input logic [31:0] a,
                             input logic [31:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.action <= act;
        in_data.operand_a <= a;
        in_data.operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note_item(in_data);
    endtask

    // Operands lean toward the edges of the range and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return $urandom_range(2) - 1;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (book.owed.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] edge_vals[6];
        book = new();
        cycles = 0;
        send_idle = 6;
        recv_idle = 75;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                      32'h0000_2000, 32'hffff_e000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every action on the extremes, halfway rounding, zero
        // divisors, the most negative value over minus one and unused codes.
        for (int act = ACT_INT_TO_FIX; act <= ACT_DIV_FIX; act++)
            send_item(act[3:0], edge_vals[act % 6], edge_vals[(act + 1) % 6]);
        send_item(ACT_ROUND, 32'hffff_e000, 32'h0);
        send_item(ACT_ROUND, 32'h0000_6000, 32'h0);
        send_item(ACT_DIV_INT, 32'h1234, 32'h0);
        send_item(ACT_DIV_FIX, 32'h8000_0000, 32'h0);
        send_item(ACT_DIV_INT, 32'h8000_0000, 32'hffff_ffff);
        send_item(ACT_DIV_FIX, 32'h8000_0000, 32'hffff_ffff);
        send_item(ACT_MUL_FIX, 32'h8000_0000, 32'h8000_0000);
        send_item(4'd11, 32'h7fff_ffff, 32'h0);
        send_item(4'd15, 32'hffff_ffff, 32'hffff_ffff);

        // Sender waits here until the pipeline has emptied.
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 6 : (phase == 1) ? 75 : 0;
            recv_idle = (phase == 0) ? 75 : (phase == 1) ? 6 : 0;
            for (int i = 0; i < 480; i++)
                send_item($urandom_range(20) == 0 ? 4'($urandom_range(15, 11))
                                                  : 4'($urandom_range(10)),
                          pick_operand(), pick_operand());
        end
        drain();

        if (book.mismatches == 0 && book.owed.size() == 0)
            $display("fixed_point_17_14_alu_tb OK");
        else
            $display("fixed_point_17_14_alu_tb NOT OK");
        $finish;
    end
endmodule
